[hdl/tde_pkg.sv]
// ----------------------------------------------------------------------------
// tde_pkg
// Shared types, constants and helpers for the trie dictionary encoder.
// ----------------------------------------------------------------------------
package tde_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int CODE_WIDTH = 12;
    localparam int ROOT_COUNT = 256;

    localparam int NODE_W   = $clog2(NODE_COUNT);
    localparam int SYM_W    = 8;
    localparam int CHILD_AW = NODE_W + SYM_W;
    localparam int PEND_W   = 3 * CODE_WIDTH;
    localparam int WORD_W   = 4 * CODE_WIDTH;
    localparam int OUT_W    = 48;

    // bytes in a partial word holding one to four codes
    localparam int BYTES_1 = (CODE_WIDTH + 7) / 8;
    localparam int BYTES_2 = (2 * CODE_WIDTH + 7) / 8;
    localparam int BYTES_3 = (3 * CODE_WIDTH + 7) / 8;
    localparam int BYTES_4 = (4 * CODE_WIDTH + 7) / 8;
    localparam int BYTES_FULL = 6;

    typedef enum logic [1:0] {
        OP_WRITE_CHILD = 2'd0,
        OP_WRITE_CODE  = 2'd1,
        OP_DATA        = 2'd2,
        OP_END         = 2'd3
    } tde_op_t;

    typedef enum logic [1:0] {
        RD_ITEM      = 2'd0,
        RD_PAD_START = 2'd1,
        RD_PAD_NEXT  = 2'd2
    } tde_rd_src_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [9:0]  node_index;
        logic [7:0]  symbol;
        logic [11:0] write_value;
    } tde_item_t;

    typedef struct packed {
        logic [47:0] packed_codes;
        logic [2:0]  byte_count;
        logic        last;
    } tde_result_t;

    typedef struct packed {
        logic        wr_child;
        logic        wr_code;
        logic        start;
        logic        rd_en;
        tde_rd_src_t rd_src;
        logic        advance;
        logic        append;
        logic        emit_full;
        logic        pad_advance;
        logic        emit_pad;
        logic        emit_empty;
    } tde_cmd_t;

    typedef struct packed {
        logic started;
        logic root_hit;
        logic count_full;
        logic pad_done;
        logic out_free;
    } tde_status_t;

    function automatic logic [2:0] tde_partial_bytes(input logic [1:0] count);
        logic [2:0] bytes;
        case (count)
            2'd0:    bytes = 3'(BYTES_1);
            2'd1:    bytes = 3'(BYTES_2);
            2'd2:    bytes = 3'(BYTES_3);
            2'd3:    bytes = 3'(BYTES_4);
            default: bytes = 3'(BYTES_1);
        endcase
        return bytes;
    endfunction

endpackage

[hdl/tde_datapath.sv]
// ----------------------------------------------------------------------------
// tde_datapath
// Trie tables, match state, code packing and the result register.
// ----------------------------------------------------------------------------
module tde_datapath
    import tde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tde_item_t   item,
    input  tde_cmd_t    cmd,
    input  logic        result_stall,
    output tde_status_t status,
    output logic        result_valid,
    output tde_result_t result
);

    logic [NODE_W-1:0]     child_mem [0:(1 << CHILD_AW) - 1];
    logic [CODE_WIDTH-1:0] code_mem  [0:NODE_COUNT - 1];

    logic [NODE_W-1:0]     child_rdata_reg;
    logic [CODE_WIDTH-1:0] code_rdata_reg;

    logic [NODE_W-1:0]     cur_reg, cur_next;
    logic                  started_reg, started_next;
    logic [PEND_W-1:0]     pend_reg, pend_next;
    logic [1:0]            count_reg, count_next;
    logic [NODE_W-1:0]     steps_reg, steps_next;
    logic                  out_valid_reg, out_valid_next;
    tde_result_t           out_reg, out_next;

    logic [CHILD_AW-1:0]   child_waddr;
    logic [CHILD_AW-1:0]   child_raddr;
    logic [NODE_W-1:0]     code_raddr;
    logic [WORD_W-1:0]     word;
    logic                  load;

    assign child_waddr = {NODE_W'(item.node_index), item.symbol};

    always_comb
    begin
        case (cmd.rd_src)
            RD_ITEM:
            begin
                child_raddr = {cur_reg, item.symbol};
                code_raddr  = cur_reg;
            end
            RD_PAD_START:
            begin
                child_raddr = {cur_reg, SYM_W'(0)};
                code_raddr  = cur_reg;
            end
            RD_PAD_NEXT:
            begin
                child_raddr = {child_rdata_reg, SYM_W'(0)};
                code_raddr  = child_rdata_reg;
            end
            default:
            begin
                child_raddr = {cur_reg, item.symbol};
                code_raddr  = cur_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_child)
        begin
            child_mem[child_waddr] <= NODE_W'(item.write_value);
        end
        if (cmd.rd_en)
        begin
            child_rdata_reg <= child_mem[child_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_code)
        begin
            code_mem[NODE_W'(item.node_index)] <= CODE_WIDTH'(item.write_value);
        end
        if (cmd.rd_en)
        begin
            code_rdata_reg <= code_mem[code_raddr];
        end
    end

    // pending codes plus the one just looked up, at the next free slot
    assign word = WORD_W'(pend_reg)
                | (WORD_W'(code_rdata_reg) << (CODE_WIDTH * int'(count_reg)));

    assign load = cmd.emit_full || cmd.emit_pad || cmd.emit_empty;

    always_comb
    begin
        cur_next       = cur_reg;
        started_next   = started_reg;
        pend_next      = pend_reg;
        count_next     = count_reg;
        steps_next     = steps_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;

        if (cmd.start)
        begin
            started_next = 1'b1;
            cur_next     = NODE_W'(item.symbol);
        end
        if (cmd.rd_en && cmd.rd_src == RD_PAD_START)
        begin
            steps_next = '0;
        end
        if (cmd.advance)
        begin
            cur_next = child_rdata_reg;
        end
        if (cmd.append)
        begin
            cur_next   = child_rdata_reg;
            pend_next  = PEND_W'(word);
            count_next = count_reg + 2'd1;
        end
        if (cmd.pad_advance)
        begin
            cur_next   = child_rdata_reg;
            steps_next = steps_reg + NODE_W'(1);
        end
        if (cmd.emit_full)
        begin
            cur_next            = child_rdata_reg;
            pend_next           = '0;
            count_next          = '0;
            out_next.packed_codes = OUT_W'(word);
            out_next.byte_count = 3'(BYTES_FULL);
            out_next.last       = 1'b0;
        end
        if (cmd.emit_pad)
        begin
            out_next.packed_codes = OUT_W'(word);
            out_next.byte_count = tde_partial_bytes(count_reg);
            out_next.last       = 1'b1;
        end
        if (cmd.emit_empty)
        begin
            out_next.packed_codes = '0;
            out_next.byte_count = '0;
            out_next.last       = 1'b1;
        end
        if (cmd.emit_pad || cmd.emit_empty)
        begin
            cur_next     = '0;
            started_next = 1'b0;
            pend_next    = '0;
            count_next   = '0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            started_reg   <= 1'b0;
            pend_reg      <= '0;
            count_reg     <= '0;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg       <= cur_next;
            started_reg   <= started_next;
            pend_reg      <= pend_next;
            count_reg     <= count_next;
            steps_reg     <= steps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign status.started    = started_reg;
    assign status.root_hit   = child_rdata_reg < NODE_W'(ROOT_COUNT);
    assign status.count_full = count_reg == 2'd3;
    assign status.pad_done   = (child_rdata_reg < NODE_W'(ROOT_COUNT))
                            || (steps_reg == NODE_W'(NODE_COUNT - 1));
    assign status.out_free   = !out_valid_reg || !result_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

[hdl/tde_controller.sv]
// ----------------------------------------------------------------------------
// tde_controller
// Sequences table writes, trie lookups, the end-of-stream padding walk
// and result hand-off.
// ----------------------------------------------------------------------------
module tde_controller
    import tde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic [1:0]  operation,
    input  tde_status_t status,
    output logic        item_stall,
    output tde_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_STEP  = 4'b0010,
        ST_PAD   = 4'b0100,
        ST_EMPTY = 4'b1000
    } tde_state_t;

    tde_state_t state_reg, state_next;
    logic       accept;

    assign item_stall = state_reg != ST_IDLE;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_src = RD_ITEM;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        OP_WRITE_CHILD: cmd.wr_child = 1'b1;
                        OP_WRITE_CODE:  cmd.wr_code = 1'b1;
                        OP_DATA:
                        begin
                            if (!status.started)
                            begin
                                cmd.start = 1'b1;
                            end
                            else
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_src = RD_ITEM;
                                state_next = ST_STEP;
                            end
                        end
                        OP_END:
                        begin
                            if (!status.started)
                            begin
                                state_next = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_src = RD_PAD_START;
                                state_next = ST_PAD;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_STEP:
            begin
                // child still inside the dictionary: keep growing the match
                if (!status.root_hit)
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (!status.count_full)
                begin
                    cmd.append = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.emit_full = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                if (!status.pad_done)
                begin
                    cmd.rd_en       = 1'b1;
                    cmd.rd_src      = RD_PAD_NEXT;
                    cmd.pad_advance = 1'b1;
                end
                else if (status.out_free)
                begin
                    cmd.emit_pad = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_EMPTY:
            begin
                if (status.out_free)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/trie_dictionary_encoder_12bit_core.sv]
// ----------------------------------------------------------------------------
// trie_dictionary_encoder_12bit_core
// Greedy longest-match trie encoder packing up to four 12-bit codes per result.
// ----------------------------------------------------------------------------
// table writes and a stream's first byte are taken on accept; later data bytes are
// accepted, then resolved from the registered read of the child table memory
// end of stream walks k padding steps (1 to NODE_COUNT), each step one child
// table read; an empty stream goes straight to its empty result
// a result is valid the cycle after it is formed and waits in an output register
// reset clears match state, packer and output valid; tables stay undefined
module trie_dictionary_encoder_12bit_core
    import tde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  tde_item_t   item,
    output logic        result_valid,
    input  logic        result_stall,
    output tde_result_t result
);

    tde_cmd_t    cmd;
    tde_status_t status;

    tde_controller u_controller (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .operation  (item.operation),
        .status     (status),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    tde_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .result_stall (result_stall),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the trie dictionary encoder core. A short table of
// directed transactions (empty stream, all-ones codes, partial words, a
// padding walk caught in a loop) is followed by random trie loads and byte
// streams. Every accepted input runs through a behavioral copy of the
// encoder, and each output transaction is compared against the oldest
// predicted word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
    import tde_pkg::*;
();

    localparam int RANDOM_ITEMS  = 1420;
    localparam int DIRECTED_ROWS = 28;
    localparam int HOLD_CYCLES   = 400;
    localparam int TAIL_CYCLES   = 50;

    typedef struct {
        tde_item_t   item;
        bit          fixed;
        tde_result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    tde_item_t   item = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    tde_result_t result;

    // encoder state as predicted from accepted transactions
    logic [9:0]  trie_child [0:262143];
    logic [11:0] trie_code [0:1023];
    bit          child_known [0:262143];
    bit          code_known [0:1023];
    logic [9:0]  walk_node = '0;
    bit          stream_open = 1'b0;
    logic [35:0] pend_bits = '0;
    int          pend_cnt = 0;

    tde_result_t expected_words [$];
    int          items_sent = 0;
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;
    logic [7:0]  hot_syms [0:3];

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{'{OP_END,         10'h000, 8'h00, 12'h000}, 1'b1, '{48'h0, 3'd0, 1'b1}},
        '{'{OP_WRITE_CODE,  10'h3FF, 8'h00, 12'hFFF}, 1'b0, '0},
        '{'{OP_WRITE_CODE,  10'h0FF, 8'h00, 12'hFFF}, 1'b0, '0},
        '{'{OP_WRITE_CHILD, 10'h0FF, 8'hFF, 12'h0FF}, 1'b0, '0},
        '{'{OP_WRITE_CHILD, 10'h0FF, 8'h00, 12'hFFF}, 1'b0, '0},
        '{'{OP_WRITE_CHILD, 10'h3FF, 8'h00, 12'hC00}, 1'b0, '0},
        '{'{OP_WRITE_CHILD, 10'h3FF, 8'hFF, 12'h800}, 1'b0, '0},
        '{'{OP_DATA,        10'h000, 8'hFF, 12'h000}, 1'b0, '0},
        '{'{OP_DATA,        10'h000, 8'hFF, 12'h000}, 1'b0, '0},
        '{'{OP_DATA,        10'h000, 8'hFF, 12'h000}, 1'b0, '0},
        '{'{OP_DATA,        10'h000, 8'hFF, 12'h000}, 1'b0, '0},
        '{'{OP_DATA,        10'h000, 8'hFF, 12'h000}, 1'b1, '{48'hFFFF_FFFF_FFFF, 3'd6, 1'b0}},
        '{'{OP_DATA,        10'h000, 8'h00, 12'h000}, 1'b0, '0},
        '{'{OP_DATA,        10'h000, 8'hFF, 12'h000}, 1'b0, '0},
        '{'{OP_WRITE_CODE,  10'h000, 8'h00, 12'h000}, 1'b0, '0},
        '{'{OP_WRITE_CHILD, 10'h000, 8'h00, 12'h001}, 1'b0, '0},
        '{'{OP_END,         10'h000, 8'h00, 12'h000}, 1'b1, '{48'h0000_0000_0FFF, 3'd3, 1'b1}},
        '{'{OP_DATA,        10'h000, 8'hFF, 12'h000}, 1'b0, '0},
        '{'{OP_DATA,        10'h000, 8'hFF, 12'h000}, 1'b0, '0},
        '{'{OP_DATA,        10'h000, 8'hFF, 12'h000}, 1'b0, '0},
        '{'{OP_DATA,        10'h000, 8'hFF, 12'h000}, 1'b0, '0},
        '{'{OP_END,         10'h000, 8'h00, 12'h000}, 1'b1, '{48'hFFFF_FFFF_FFFF, 3'd6, 1'b1}},
        // self loop on the byte-0 child: the padding walk runs out of steps
        '{'{OP_WRITE_CODE,  10'h200, 8'h00, 12'h123}, 1'b0, '0},
        '{'{OP_WRITE_CHILD, 10'h200, 8'h00, 12'h200}, 1'b0, '0},
        '{'{OP_WRITE_CHILD, 10'h0FF, 8'h01, 12'h200}, 1'b0, '0},
        '{'{OP_DATA,        10'h000, 8'hFF, 12'h000}, 1'b0, '0},
        '{'{OP_DATA,        10'h000, 8'h01, 12'h000}, 1'b0, '0},
        '{'{OP_END,         10'h000, 8'h00, 12'h000}, 1'b0, '0}
    };

    trie_dictionary_encoder_12bit_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // one accepted transaction through the encoder
    function automatic void encode_step(input tde_item_t it, output tde_result_t res,
                                        output bit got);
        logic [9:0]  prev;
        logic [9:0]  nxt;
        logic [47:0] word;
        int          steps;
        int          nbits;
        got = 1'b0;
        res = '0;
        case (tde_op_t'(it.operation))
            OP_WRITE_CHILD:
            begin
                trie_child[{it.node_index, it.symbol}] = it.write_value[9:0];
                child_known[{it.node_index, it.symbol}] = 1'b1;
            end
            OP_WRITE_CODE:
            begin
                trie_code[it.node_index] = it.write_value;
                code_known[it.node_index] = 1'b1;
            end
            OP_DATA:
            begin
                if (!stream_open)
                begin
                    stream_open = 1'b1;
                    walk_node = {2'b00, it.symbol};
                end
                else
                begin
                    prev = walk_node;
                    nxt = trie_child[{prev, it.symbol}];
                    walk_node = nxt;
                    // falling back to a root closes the current match
                    if (nxt < ROOT_COUNT)
                    begin
                        word = {12'h000, pend_bits}
                             | (48'(trie_code[prev]) << (CODE_WIDTH * pend_cnt));
                        if (pend_cnt == 3)
                        begin
                            res = '{packed_codes: word, byte_count: 3'd6, last: 1'b0};
                            got = 1'b1;
                            pend_bits = '0;
                            pend_cnt = 0;
                        end
                        else
                        begin
                            pend_bits = word[35:0];
                            pend_cnt++;
                        end
                    end
                end
            end
            default:
            begin
                word = '0;
                nbits = 0;
                if (stream_open)
                begin
                    nxt = walk_node;
                    prev = walk_node;
                    steps = 0;
                    do
                    begin
                        prev = nxt;
                        nxt = trie_child[{nxt, 8'h00}];
                        steps++;
                    end while (nxt >= ROOT_COUNT && steps < NODE_COUNT);
                    word = {12'h000, pend_bits}
                         | (48'(trie_code[prev]) << (CODE_WIDTH * pend_cnt));
                    nbits = CODE_WIDTH * (pend_cnt + 1);
                end
                res = '{packed_codes: word, byte_count: 3'((nbits + 7) / 8), last: 1'b1};
                got = 1'b1;
                stream_open = 1'b0;
                walk_node = '0;
                pend_bits = '0;
                pend_cnt = 0;
            end
        endcase
    endfunction

    // fields the operation ignores get random values
    function automatic tde_item_t make_item(tde_op_t op, logic [9:0] nd, logic [7:0] sym,
                                            logic [11:0] val);
        tde_item_t it;
        it.operation = op;
        it.node_index = (op == OP_DATA || op == OP_END) ? 10'($urandom) : nd;
        it.symbol = (op == OP_WRITE_CODE || op == OP_END) ? 8'($urandom) : sym;
        it.write_value = (op == OP_DATA || op == OP_END) ? 12'($urandom) : val;
        return it;
    endfunction

    task automatic send_item(input tde_item_t it, input bit fixed, input tde_result_t want);
        tde_result_t res;
        bit          got;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (item_stall);
        encode_step(it, res, got);
        if (got)
            expected_words = {expected_words, (fixed ? want : res)};
        items_sent++;
    endtask

    // load a child link on demand so no lookup ever hits an unwritten entry
    task automatic ensure_child(input logic [9:0] nd, input logic [7:0] sym, input int root_pct);
        int target;
        if (!child_known[{nd, sym}])
        begin
            target = ($urandom_range(0, 99) < root_pct) ? $urandom_range(0, ROOT_COUNT - 1)
                                                         : $urandom_range(ROOT_COUNT, NODE_COUNT - 1);
            send_item(make_item(OP_WRITE_CHILD, nd, sym, {2'($urandom), 10'(target)}), 1'b0, '0);
        end
    endtask

    task automatic ensure_code(input logic [9:0] nd);
        if (!code_known[nd])
            send_item(make_item(OP_WRITE_CODE, nd, 8'h00, 12'($urandom)), 1'b0, '0);
    endtask

    task automatic random_stream();
        int         len;
        int         steps;
        logic [7:0] sym;
        logic [9:0] nd;
        logic [9:0] prev;
        if ($urandom_range(0, 9) == 0)
            len = 0;
        else if ($urandom_range(0, 7) == 0)
            len = $urandom_range(20, 60);
        else
            len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
        begin
            sym = ($urandom_range(0, 3) == 0) ? 8'($urandom) : hot_syms[$urandom_range(0, 3)];
            // stray table writes, also in the middle of a stream
            if ($urandom_range(0, 19) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_item(make_item(OP_WRITE_CHILD, 10'($urandom), 8'($urandom),
                                        12'($urandom)), 1'b0, '0);
                else
                    send_item(make_item(OP_WRITE_CODE, 10'($urandom), 8'h00,
                                        12'($urandom)), 1'b0, '0);
            end
            if (stream_open)
            begin
                ensure_child(walk_node, sym, 45);
                if (trie_child[{walk_node, sym}] < ROOT_COUNT)
                    ensure_code(walk_node);
            end
            send_item(make_item(OP_DATA, 10'h000, sym, 12'h000), 1'b0, '0);
        end
        // make every step of the padding walk land on a loaded entry
        if (stream_open)
        begin
            nd = walk_node;
            prev = walk_node;
            steps = 0;
            do
            begin
                ensure_child(nd, 8'h00, 85);
                prev = nd;
                nd = trie_child[{nd, 8'h00}];
                steps++;
            end while (nd >= ROOT_COUNT && steps < NODE_COUNT);
            ensure_code(prev);
        end
        send_item(make_item(OP_END, 10'h000, 8'h00, 12'h000), 1'b0, '0);
    endtask

    // receiver side: random stalls plus one long hold-off
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // output transaction check
    always @(posedge clk)
    begin
        tde_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected result: packed_codes %h byte_count %0d last %0d",
                       result.packed_codes, result.byte_count, result.last);
                fail_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (result.packed_codes !== want.packed_codes)
                begin
                    $error("packed_codes: expected %h, got %h",
                           want.packed_codes, result.packed_codes);
                    fail_count++;
                end
                if (result.byte_count !== want.byte_count)
                begin
                    $error("byte_count: expected %0d, got %0d", want.byte_count, result.byte_count);
                    fail_count++;
                end
                if (result.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, result.last);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int phase_end;
        for (int k = 0; k < 4; k++)
            hot_syms[k] = 8'($urandom);
        send_idle_pct = 14;
        recv_idle_pct = 60;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            send_item(directed_rows[r].item, directed_rows[r].fixed, directed_rows[r].want);

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 60 : 0;
            recv_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 14 : 0;
            if (ph == 2)
                hold_req <= 1'b1;
            phase_end = DIRECTED_ROWS + (ph + 1) * RANDOM_ITEMS / 3;
            while (items_sent < phase_end)
                random_stream();
        end
        item_valid <= 1'b0;

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #100_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
